// ===== hw/rtl/ssrp_pkg.sv =====
// ----------------------------------------------------------------------------
// ssrp_pkg
// shared types and constants of the sorted shelf rectangle packer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package ssrp_pkg;

  localparam int MaxImagesDef = 64;
  localparam int CoordBitsDef = 12;
  localparam int CfgBits      = 12;
  localparam int PosBits      = 6;
  localparam int FaultBits    = 2;

  localparam logic CfgIdxHeight = 1'b0;
  localparam logic CfgIdxWidth  = 1'b1;

  localparam logic [FaultBits-1:0] FaultNone    = 2'd0;
  localparam logic [FaultBits-1:0] FaultTall    = 2'd1;
  localparam logic [FaultBits-1:0] FaultWide    = 2'd2;
  localparam logic [FaultBits-1:0] FaultDropped = 2'd3;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_SORT_RD,
    ST_SORT_CMP,
    ST_PLACE_RD,
    ST_PLACE_OUT
  } state_e;

  // commands from the controller to the datapath
  typedef struct packed {
    logic store;       // write incoming word into the next free slot
    logic sort_rd;     // read sort operands j and j+1
    logic sort_cmp;    // compare and swap if out of order
    logic place_init;  // clear shelf state
    logic place_rd;    // read entry at place index
    logic place_out;   // emit one result
    logic run_end;     // clear count and dropped flag
  } ctrl_t;

  typedef struct packed {
    logic sort_pass_done;   // inner index reached end of pass
    logic sort_done;        // no more passes
    logic place_last;       // current entry is last
    logic empty;            // nothing stored
  } stat_t;

endpackage
`default_nettype wire

// ===== hw/rtl/ssrp_ctrl.sv =====
// ----------------------------------------------------------------------------
// ssrp_ctrl
// sequencer for loading, bubble sort passes and placement
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module ssrp_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start,
  input  wire logic           last_rect_i,
  input  wire ssrp_pkg::stat_t stat_i,
  output ssrp_pkg::ctrl_t     ctrl_o,
  output logic                busy
);
  import ssrp_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    ctrl_o  = '0;
    busy    = 1'b1;
    case (state_q)
      ST_LOAD: begin
        busy = 1'b0;
        if (start) begin
          ctrl_o.store = 1'b1;
          if (last_rect_i) begin
            state_d = ST_SORT_RD;
          end
        end
      end
      ST_SORT_RD: begin
        if (stat_i.sort_done) begin
          ctrl_o.place_init = 1'b1;
          state_d = ST_PLACE_RD;
        end else begin
          ctrl_o.sort_rd = 1'b1;
          state_d = ST_SORT_CMP;
        end
      end
      ST_SORT_CMP: begin
        ctrl_o.sort_cmp = 1'b1;
        state_d = ST_SORT_RD;
      end
      ST_PLACE_RD: begin
        ctrl_o.place_rd = 1'b1;
        state_d = ST_PLACE_OUT;
      end
      ST_PLACE_OUT: begin
        ctrl_o.place_out = 1'b1;
        if (stat_i.place_last) begin
          ctrl_o.run_end = 1'b1;
          state_d = ST_LOAD;
        end else begin
          state_d = ST_PLACE_RD;
        end
      end
      default: state_d = ST_LOAD;
    endcase
  end

endmodule
`default_nettype wire

// ===== hw/rtl/ssrp_datapath.sv =====
// ----------------------------------------------------------------------------
// ssrp_datapath
// rectangle store, bubble sorting and shelf placement arithmetic
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module ssrp_datapath #(
  parameter int MaxImages = ssrp_pkg::MaxImagesDef,
  parameter int CoordBits = ssrp_pkg::CoordBitsDef
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire ssrp_pkg::ctrl_t            ctrl_i,
  output ssrp_pkg::stat_t                 stat_o,
  input  wire logic [CoordBits-1:0]       atlas_height_i,
  input  wire logic [CoordBits-1:0]       atlas_width_i,
  input  wire logic [CoordBits-1:0]       rect_width_i,
  input  wire logic [CoordBits-1:0]       rect_height_i,
  output logic                            result_valid_o,
  output logic [ssrp_pkg::PosBits-1:0]    load_position_o,
  output logic [CoordBits-1:0]            left_edge_o,
  output logic [CoordBits-1:0]            top_edge_o,
  output logic [CoordBits-1:0]            right_edge_o,
  output logic [CoordBits-1:0]            bottom_edge_o,
  output logic                            final_result_o,
  output logic [CoordBits-1:0]            used_width_o,
  output logic [CoordBits-1:0]            used_height_o,
  output logic [ssrp_pkg::FaultBits-1:0]  fault_o
);
  import ssrp_pkg::*;

  localparam int IdxBits = (MaxImages > 1) ? $clog2(MaxImages) : 1;
  localparam int CntBits = $clog2(MaxImages + 1);
  localparam int EntBits = 2 * CoordBits + PosBits;
  localparam logic [CntBits-1:0] Full = CntBits'(MaxImages);
  localparam logic [CoordBits:0] CoordMax = {1'b0, {CoordBits{1'b1}}};

  // one entry: width, height, load position
  logic [EntBits-1:0] mem_q [MaxImages];

  logic [CntBits-1:0] count_q;
  logic               dropped_q;
  logic [IdxBits-1:0] j_q;          // inner sort index / place index
  logic               swapped_q;
  logic [EntBits-1:0] ra_q, rb_q;

  logic [CoordBits-1:0] shelf_left_q, shelf_top_q, shelf_width_q;
  logic [CoordBits-1:0] max_right_q, max_bottom_q;

  logic [IdxBits-1:0] jn;
  assign jn = j_q + 1'b1;

  // place index plus one at count width, so a full store ends cleanly
  logic [CntBits-1:0] jc;
  assign jc = CntBits'(j_q) + CntBits'(1);

  // a before b: wider, or same width and taller
  logic [CoordBits-1:0] wa, ha, wb, hb;
  logic                 b_first;
  assign wa = ra_q[EntBits-1 -: CoordBits];
  assign ha = ra_q[PosBits +: CoordBits];
  assign wb = rb_q[EntBits-1 -: CoordBits];
  assign hb = rb_q[PosBits +: CoordBits];
  assign b_first = (wb != wa) ? (wb > wa) : (hb > ha);

  logic pass_end;
  assign pass_end = ({1'b0, jn} + 1'b1) >= {1'b0, count_q};

  assign stat_o.sort_pass_done = pass_end;
  assign stat_o.place_last     = (jc == count_q);
  assign stat_o.empty          = (count_q == '0);

  // sort pass state: swapped flag marks a pass with exchanges
  logic sort_started_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.store && count_q != Full) begin
      mem_q[count_q[IdxBits-1:0]] <= {rect_width_i, rect_height_i,
                                      PosBits'(count_q)};
    end
    if (ctrl_i.sort_rd || ctrl_i.place_rd) begin
      ra_q <= mem_q[j_q];
      rb_q <= mem_q[jn];
    end
    if (ctrl_i.sort_cmp && b_first) begin
      mem_q[j_q] <= rb_q;
      mem_q[jn]  <= ra_q;
    end
  end

  // sort and place index and pass tracking
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      j_q            <= '0;
      swapped_q      <= 1'b0;
      sort_started_q <= 1'b0;
    end else begin
      if (ctrl_i.store) begin
        j_q            <= '0;
        swapped_q      <= 1'b0;
        sort_started_q <= 1'b0;
      end else if (ctrl_i.sort_cmp) begin
        sort_started_q <= 1'b1;
        if (pass_end) begin
          j_q       <= '0;
          swapped_q <= 1'b0;
        end else begin
          j_q       <= jn;
          swapped_q <= swapped_q | b_first;
        end
      end else if (ctrl_i.place_init) begin
        j_q <= '0;
      end else if (ctrl_i.place_out) begin
        j_q <= jn;
      end
    end
  end

  // pass ended clean when a full pass had no swap: tracked via a flag
  // set at the end of each pass
  logic clean_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clean_q <= 1'b0;
    end else if (ctrl_i.store) begin
      clean_q <= 1'b0;
    end else if (ctrl_i.sort_cmp && pass_end) begin
      clean_q <= !(swapped_q | b_first);
    end
  end

  logic sort_finished;
  assign sort_finished = (count_q < CntBits'(2)) || (sort_started_q && clean_q &&
                         j_q == '0);

  assign stat_o.sort_done = sort_finished;

  // placement arithmetic on entry ra
  logic [CoordBits-1:0] rw, rh;
  logic [CoordBits:0]   sum_top, sum_left, right_raw;
  logic [CoordBits-1:0] sw_eff, left_n, top_n, right_n;
  logic                 tall, new_shelf;
  assign rw = wa;
  assign rh = ha;
  assign tall = rh > atlas_height_i;
  assign sw_eff = (shelf_width_q == '0) ? rw : shelf_width_q;
  assign sum_top = {1'b0, rh} + {1'b0, shelf_top_q};
  assign new_shelf = sum_top > {1'b0, atlas_height_i};
  assign sum_left = {1'b0, shelf_left_q} + {1'b0, sw_eff};
  assign left_n = new_shelf ? ((sum_left > CoordMax) ? CoordMax[CoordBits-1:0]
                              : sum_left[CoordBits-1:0]) : shelf_left_q;
  assign top_n = new_shelf ? '0 : shelf_top_q;
  assign right_raw = {1'b0, left_n} + {1'b0, rw};
  assign right_n = (right_raw > CoordMax) ? CoordMax[CoordBits-1:0]
                  : right_raw[CoordBits-1:0];

  logic [CoordBits-1:0] bottom_n;
  assign bottom_n = top_n + rh;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q        <= '0;
      dropped_q      <= 1'b0;
      result_valid_o <= 1'b0;
      shelf_left_q   <= '0;
      shelf_top_q    <= '0;
      shelf_width_q  <= '0;
      max_right_q    <= '0;
      max_bottom_q   <= '0;
    end else begin
      result_valid_o <= 1'b0;
      if (ctrl_i.store) begin
        if (count_q != Full) begin
          count_q <= count_q + 1'b1;
        end else begin
          dropped_q <= 1'b1;
        end
      end
      if (ctrl_i.place_init) begin
        shelf_left_q  <= '0;
        shelf_top_q   <= '0;
        shelf_width_q <= '0;
        max_right_q   <= '0;
        max_bottom_q  <= '0;
      end
      if (ctrl_i.place_out) begin
        result_valid_o  <= 1'b1;
        load_position_o <= ra_q[PosBits-1:0];
        final_result_o  <= stat_o.place_last;
        if (tall) begin
          left_edge_o   <= '0;
          top_edge_o    <= '0;
          right_edge_o  <= '0;
          bottom_edge_o <= '0;
          used_width_o  <= max_right_q;
          used_height_o <= max_bottom_q;
          fault_o       <= FaultTall;
        end else begin
          shelf_left_q  <= left_n;
          shelf_top_q   <= bottom_n;
          shelf_width_q <= new_shelf ? rw : sw_eff;
          left_edge_o   <= left_n;
          top_edge_o    <= top_n;
          right_edge_o  <= right_n;
          bottom_edge_o <= bottom_n;
          if (right_n > max_right_q) max_right_q <= right_n;
          if (bottom_n > max_bottom_q) max_bottom_q <= bottom_n;
          used_width_o  <= (right_n > max_right_q) ? right_n : max_right_q;
          used_height_o <= (bottom_n > max_bottom_q) ? bottom_n : max_bottom_q;
          if (right_raw > {1'b0, atlas_width_i}) begin
            fault_o <= FaultWide;
          end else if (stat_o.place_last && dropped_q) begin
            fault_o <= FaultDropped;
          end else begin
            fault_o <= FaultNone;
          end
        end
      end
      if (ctrl_i.run_end) begin
        count_q   <= '0;
        dropped_q <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/sorted_shelf_rectangle_packer_top.sv =====
// ----------------------------------------------------------------------------
// sorted_shelf_rectangle_packer_top
// loads rectangles one per cycle while idle, sorts them and places them in shelves
// ----------------------------------------------------------------------------
// A rectangle is taken in each cycle with start high and busy low. On the
// rectangle marked last the block sorts the set with a bubble sort over the
// single store (each compare reads a pair, then swaps it if out of order) and
// then emits the results one by one, each entry read and then shown, strobed by
// result_valid_o; the receiver cannot stall and must take each word as shown.
`timescale 1ns / 1ps
`default_nettype none
module sorted_shelf_rectangle_packer_top #(
  parameter int MaxImages = ssrp_pkg::MaxImagesDef,
  parameter int CoordBits = ssrp_pkg::CoordBitsDef
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_we_i,
  input  wire logic                       cfg_idx_i,
  input  wire logic [ssrp_pkg::CfgBits-1:0] cfg_data_i,
  input  wire logic                       start,
  output logic                            busy,
  input  wire logic [CoordBits-1:0]       rect_width_i,
  input  wire logic [CoordBits-1:0]       rect_height_i,
  input  wire logic                       last_rect_i,
  output logic                            result_valid_o,
  output logic [ssrp_pkg::PosBits-1:0]    load_position_o,
  output logic [CoordBits-1:0]            left_edge_o,
  output logic [CoordBits-1:0]            top_edge_o,
  output logic [CoordBits-1:0]            right_edge_o,
  output logic [CoordBits-1:0]            bottom_edge_o,
  output logic                            final_result_o,
  output logic [CoordBits-1:0]            used_width_o,
  output logic [CoordBits-1:0]            used_height_o,
  output logic [ssrp_pkg::FaultBits-1:0]  fault_o
);
  import ssrp_pkg::*;

  logic [CoordBits-1:0] atlas_height_q, atlas_width_q;
  ctrl_t ctrl;
  stat_t stat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      atlas_height_q <= CoordBits'(256);
      atlas_width_q  <= CoordBits'(256);
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CfgIdxHeight) atlas_height_q <= CoordBits'(cfg_data_i);
      if (cfg_idx_i == CfgIdxWidth)  atlas_width_q  <= CoordBits'(cfg_data_i);
    end
  end

  ssrp_ctrl u_ctrl (
    .clk_i, .rst_ni, .start, .last_rect_i,
    .stat_i (stat), .ctrl_o (ctrl), .busy
  );

  ssrp_datapath #(.MaxImages(MaxImages), .CoordBits(CoordBits)) u_dp (
    .clk_i, .rst_ni, .ctrl_i (ctrl), .stat_o (stat),
    .atlas_height_i (atlas_height_q), .atlas_width_i (atlas_width_q),
    .rect_width_i, .rect_height_i,
    .result_valid_o, .load_position_o, .left_edge_o, .top_edge_o,
    .right_edge_o, .bottom_edge_o, .final_result_o, .used_width_o,
    .used_height_o, .fault_o
  );

endmodule
`default_nettype wire
